FILE: rtl/uer_pkg.sv
// shared types, register indexes and phase codes for the echo ranger
package uer_pkg;

   localparam int CFG_W     = 20;
   localparam int TPF_W     = 16;
   localparam int FEET_W    = 20;
   localparam int CSR_IDX_W = 4;
   localparam int PHASE_W   = 3;

   localparam logic [FEET_W-1:0] FEET_MAX = {FEET_W{1'b1}};

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_SETUP_LOW    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_HIGH = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TICKS_FOOT   = 4'd3;

   // reset values of the registers
   localparam logic [CFG_W-1:0] SETUP_LOW_RST    = 20'd2000;
   localparam logic [CFG_W-1:0] TRIGGER_HIGH_RST = 20'd10;
   localparam logic [CFG_W-1:0] TIMEOUT_RST      = 20'd30000;
   localparam logic [TPF_W-1:0] TICKS_FOOT_RST   = 16'd1768;

   // measurement phases
   localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_SETUP = 3'd1;
   localparam logic [PHASE_W-1:0] PH_TRIG  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_WAIT  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_MEAS  = 3'd4;

   typedef struct packed {
      logic [CFG_W-1:0] setup_low_ticks;
      logic [CFG_W-1:0] trigger_high_ticks;
      logic [CFG_W-1:0] timeout_ticks;
      logic [TPF_W-1:0] ticks_per_foot;
   } cfg_type;

   typedef struct packed {
      logic start_req;
      logic echo;
   } req_type;

   typedef struct packed {
      logic              trigger;
      logic              busy_res;
      logic              done_res;
      logic              timed_out;
      logic [FEET_W-1:0] distance_feet;
   } rsp_type;

endpackage

FILE: rtl/uer_if.sv
// valid/ready channel interfaces for the echo ranger

interface uer_req_if import uer_pkg::*; ();
   logic valid;
   logic ready;
   logic start_req;
   logic echo;
   modport source (output valid, output start_req, output echo, input ready);
   modport sink (input valid, input start_req, input echo, output ready);
endinterface

interface uer_rsp_if import uer_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              trigger;
   logic              busy_res;
   logic              done_res;
   logic              timed_out;
   logic [FEET_W-1:0] distance_feet;
   modport source (output valid, output trigger, output busy_res, output done_res,
                   output timed_out, output distance_feet, input ready);
   modport sink (input valid, input trigger, input busy_res, input done_res,
                 input timed_out, input distance_feet, output ready);
endinterface

interface uer_csr_if import uer_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/uer_csr.sv
// configuration register file for the echo ranger
module uer_csr import uer_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   uer_csr_if.sink csr_bus,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_bus.index)
            REG_SETUP_LOW:    cfg_in.setup_low_ticks    = csr_bus.data;
            REG_TRIGGER_HIGH: cfg_in.trigger_high_ticks = csr_bus.data;
            REG_TIMEOUT:      cfg_in.timeout_ticks      = csr_bus.data;
            REG_TICKS_FOOT:   cfg_in.ticks_per_foot     = csr_bus.data[TPF_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setup_low_ticks    <= SETUP_LOW_RST;
         cfg_ff.trigger_high_ticks <= TRIGGER_HIGH_RST;
         cfg_ff.timeout_ticks      <= TIMEOUT_RST;
         cfg_ff.ticks_per_foot     <= TICKS_FOOT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/uer_core.sv
// per-tick phase sequencer, pulse timer and foot counter
module uer_core import uer_pkg::*; #(
   parameter int COUNT_WIDTH = 20
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam int LW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [TPF_W-1:0]       sub_ff, sub_in;
   logic [FEET_W-1:0]      feet_ff, feet_in;
   logic [FEET_W-1:0]      held_ff, held_in;

   logic [COUNT_WIDTH-1:0] lim_setup, lim_trig, lim_tout;
   logic                   trig, done, tout;

   // limits above the counter range are clipped to its maximum
   function automatic logic [COUNT_WIDTH-1:0] clip(input logic [CFG_W-1:0] v);
      logic [LW-1:0] ext;
      logic [LW-1:0] cmax;
      ext  = LW'(v);
      cmax = LW'({COUNT_WIDTH{1'b1}});
      if (ext > cmax) begin
         ext = cmax;
      end
      return ext[COUNT_WIDTH-1:0];
   endfunction

   assign lim_setup = clip(cfg.setup_low_ticks);
   assign lim_trig  = clip(cfg.trigger_high_ticks);
   assign lim_tout  = clip(cfg.timeout_ticks);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      sub_in   = sub_ff;
      feet_in  = feet_ff;
      held_in  = held_ff;
      trig     = 1'b0;
      done     = 1'b0;
      tout     = 1'b0;

      if (phase_in == PH_IDLE && item.start_req) begin
         phase_in = PH_SETUP;
         count_in = '0;
         sub_in   = '0;
         feet_in  = '0;
      end

      // the last setup tick already drives the pulse
      if (phase_in == PH_SETUP) begin
         if (count_in >= lim_setup) begin
            phase_in = PH_TRIG;
            count_in = '0;
         end else begin
            count_in = count_in + 1'b1;
         end
      end

      // subcounter wrap (or zero ticks per foot) adds one foot
      unique case (phase_in)
         PH_TRIG: begin
            trig     = 1'b1;
            count_in = count_in + 1'b1;
            if (count_in >= lim_trig) begin
               phase_in = PH_WAIT;
               count_in = '0;
            end
         end
         PH_WAIT: begin
            if (item.echo) begin
               phase_in = PH_MEAS;
               count_in = COUNT_WIDTH'(1);
               sub_in   = sub_in + 1'b1;
               if (sub_in >= cfg.ticks_per_foot || sub_in == '0) begin
                  sub_in = '0;
                  if (feet_in != FEET_MAX) begin
                     feet_in = feet_in + 1'b1;
                  end
               end
            end else if (count_in >= lim_tout) begin
               phase_in = PH_IDLE;
               count_in = '0;
               done     = 1'b1;
               tout     = 1'b1;
            end else begin
               count_in = count_in + 1'b1;
            end
         end
         PH_MEAS: begin
            if (!item.echo) begin
               held_in  = feet_in;
               phase_in = PH_IDLE;
               count_in = '0;
               done     = 1'b1;
            end else if (count_in >= lim_tout) begin
               phase_in = PH_IDLE;
               count_in = '0;
               done     = 1'b1;
               tout     = 1'b1;
            end else begin
               count_in = count_in + 1'b1;
               sub_in   = sub_in + 1'b1;
               if (sub_in >= cfg.ticks_per_foot || sub_in == '0) begin
                  sub_in = '0;
                  if (feet_in != FEET_MAX) begin
                     feet_in = feet_in + 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         sub_ff   <= '0;
         feet_ff  <= '0;
         held_ff  <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sub_ff   <= sub_in;
         feet_ff  <= feet_in;
         held_ff  <= held_in;
      end
   end

   assign result.trigger       = trig;
   assign result.busy_res      = (phase_in != PH_IDLE);
   assign result.done_res      = done;
   assign result.timed_out     = tout;
   assign result.distance_feet = held_in;

endmodule

FILE: rtl/ultrasonic_echo_ranger.sv
// top level of the ultrasonic echo ranger
//
//  channel  dir  handshake      payload
//  req_bus  in   valid / ready  start_req, echo
//  rsp_bus  out  valid / ready  trigger, busy_res, done_res, timed_out, distance_feet
//  csr_bus  in   valid / ready  index, data (always ready)
//
//  one word in and one word out per cycle while rsp ready is high; each word passes the input register,
//  then the phase sequencer settles in one pass into the output register
//  reset (synchronous) clears the valid bits, the phase state and the csr and core registers
//  a stalled output holds its word; the input register refills behind it, so
//  req ready drops only while both stages are full and rsp ready is low
module ultrasonic_echo_ranger import uer_pkg::*; #(
   parameter int COUNT_WIDTH = 20
) (
   input  logic      clock,
   input  logic      reset,
   uer_req_if.sink   req_bus,
   uer_rsp_if.source rsp_bus,
   uer_csr_if.sink   csr_bus
);

   // input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;

   // output stage
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;

   cfg_type cfg;
   rsp_type step_result;
   logic    out_take;
   logic    step_fire;

   // output register can load when empty or being drained
   assign out_take      = !out_valid_ff || rsp_bus.ready;
   assign step_fire     = in_valid_ff && out_take;
   assign req_bus.ready = !in_valid_ff || out_take;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (step_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_item_ff.start_req <= req_bus.start_req;
         in_item_ff.echo      <= req_bus.echo;
      end
      if (step_fire) begin
         out_item_ff <= step_result;
      end
   end

   uer_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // state advances once per word handed to the output register
   uer_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_fire),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.trigger       = out_item_ff.trigger;
   assign rsp_bus.busy_res      = out_item_ff.busy_res;
   assign rsp_bus.done_res      = out_item_ff.done_res;
   assign rsp_bus.timed_out     = out_item_ff.timed_out;
   assign rsp_bus.distance_feet = out_item_ff.distance_feet;

endmodule

FILE: rtl/uer_checker.sv
// port-level checks for the echo ranger and their binding
module uer_checker import uer_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              trigger,
   input logic              busy_res,
   input logic              done_res,
   input logic              timed_out,
   input logic [FEET_W-1:0] distance_feet
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(done_res) && $stable(distance_feet))
      else $error("result word changed while stalled");

   a_tout_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && timed_out |-> done_res)
      else $error("timeout flag without done");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> !busy_res && !trigger)
      else $error("done word still busy");

   a_trig_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && trigger |-> busy_res)
      else $error("trigger driven while idle");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .trigger       (rsp_bus.trigger),
   .busy_res      (rsp_bus.busy_res),
   .done_res      (rsp_bus.done_res),
   .timed_out     (rsp_bus.timed_out),
   .distance_feet (rsp_bus.distance_feet)
);
